@@ rtl/core/cau_pkg.sv @@
// Shared types, codes and helpers for the complex arithmetic unit.
// No dependencies.
package cau_pkg;

	typedef enum logic [2:0] {
		KIND_ADD  = 3'd0,
		KIND_SUB  = 3'd1,
		KIND_MUL  = 3'd2,
		KIND_DIV  = 3'd3,
		KIND_NEG  = 3'd4,
		KIND_CONJ = 3'd5,
		KIND_INV  = 3'd6,
		KIND_RSVD = 3'd7   // unused, returns zero with ok status
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_DZ  = 2'd1,
		ST_SAT = 2'd2
	} status_t;

	localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	// operand word carried down the pipe
	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] a_re;
		logic signed [31:0] a_im;
		logic signed [31:0] b_re;
		logic signed [31:0] b_im;
		logic               negx;  // inverse real part comes out negative
		logic               negy;  // inverse imag part comes out negative
		logic               dz;    // squared magnitude is zero
		logic [63:0]        den;
		logic [31:0]        mx;
		logic [31:0]        my;
	} carry_t;

	// restoring divider state; big marks a quotient past 33 bits
	typedef struct packed {
		logic [64:0] rem;
		logic [32:0] q;
		logic        big;
	} dstate_t;

	typedef struct packed {
		logic signed [31:0] val;
		logic               sat;
	} satv_t;

	function automatic dstate_t div_step(dstate_t d, logic [63:0] den, logic b);
		logic [64:0] r2;
		logic        qb;
		dstate_t     n;
		r2 = {d.rem[63:0], b};
		qb = (r2 >= {1'b0, den});
		n.rem = qb ? (r2 - {1'b0, den}) : r2;
		n.q   = {d.q[31:0], qb};
		n.big = d.big | d.q[32];
		return n;
	endfunction

	function automatic satv_t sat32(logic signed [64:0] v);
		satv_t r;
		if (v > 65'sh0_7FFF_FFFF) begin
			r.val = Q_MAX;
			r.sat = 1'b1;
		end else if (v < -65'sh0_8000_0000) begin
			r.val = Q_MIN;
			r.sat = 1'b1;
		end else begin
			r.val = v[31:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

	// round the quotient half up, apply the sign, saturate
	function automatic satv_t inv_fin(dstate_t d, logic [63:0] den, logic neg);
		logic        rnd;
		logic [33:0] mag;
		logic        ovf;
		satv_t       r;
		rnd = ({d.rem, 1'b0} >= {2'b00, den});
		mag = {1'b0, d.q} + {33'd0, rnd};
		ovf = d.big || (neg ? (mag > 34'h0_8000_0000) : (mag > 34'h0_7FFF_FFFF));
		r.sat = ovf;
		if (ovf) begin
			r.val = neg ? Q_MIN : Q_MAX;
		end else begin
			r.val = neg ? -mag[31:0] : mag[31:0];
		end
		return r;
	endfunction

endpackage

@@ rtl/core/complex_arithmetic_unit.sv @@
// Complex arithmetic unit top level: fully pipelined complex ALU on Q-format words.
// Depends on cau_pkg.
//
// One word in per cycle unless the output stalls, one result word out per word in,
// in order. The depth of the pipe is set by the restoring divider behind inverse
// and divide, which retires one quotient bit per stage over 2*FRAC_BITS + 33
// stages. Every operation flows through every stage so results never reorder.
// When m_tready is low with a result word held, the whole pipe freezes and s_tready
// drops in the same cycle; nothing is lost or repeated. Operands and results are
// signed 32-bit fixed point with FRAC_BITS fraction bits. Products round to nearest
// with ties up; inverse rounds half away from zero. A zero divisor returns zero with
// divide-by-zero status; any clipped component returns saturated status.
module complex_arithmetic_unit
	import cau_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,  // a_re, a_im, b_re, b_im
	input  logic [2:0]   s_tuser,  // kind
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,  // res_re, res_im
	output logic [1:0]   m_tuser   // status
);

	localparam int DIV_STEPS = 2 * FRAC_BITS + 33;

	logic en;

	// stage 1: input register
	logic   vld_s1;
	carry_t pl_s1;
	// stage 2: squares
	logic        vld_s2;
	carry_t      pl_s2;
	logic [63:0] sqx_s2, sqy_s2;
	// stage 3: squared magnitude
	logic   vld_s3;
	carry_t pl_s3;
	// stage 4: divider steps
	logic    vld_s4 [DIV_STEPS];
	carry_t  pl_s4  [DIV_STEPS];
	dstate_t dx_s4  [DIV_STEPS];
	dstate_t dy_s4  [DIV_STEPS];
	// stage 5: inverse
	logic   vld_s5;
	carry_t pl_s5;
	satv_t  ire_s5, iim_s5;
	// stage 6: partial products
	logic               vld_s6;
	carry_t             pl_s6;
	logic               isat_s6;
	logic signed [63:0] p0_s6, p1_s6, p2_s6, p3_s6;
	// stage 7: output register
	logic        vld_s7;
	logic [63:0] data_s7;
	status_t     st_s7;
	logic [2:0]  kind_s7;

	// a frozen output freezes everything upstream
	assign en       = !vld_s7 || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_s7;
	assign m_tdata  = data_s7;
	assign m_tuser  = st_s7;

	// ---------------- stage 1
	carry_t pl1_nxt;

	always_comb begin
		pl1_nxt      = '0;
		pl1_nxt.kind = s_tuser;
		pl1_nxt.a_re = s_tdata[31:0];
		pl1_nxt.a_im = s_tdata[63:32];
		pl1_nxt.b_re = s_tdata[95:64];
		pl1_nxt.b_im = s_tdata[127:96];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s1 <= pl1_nxt;
		end
	end

	// ---------------- stage 2: inverse takes a, divide takes b
	logic signed [31:0] xs, ys;
	logic [31:0]        mx, my;
	carry_t             pl2_nxt;

	always_comb begin
		xs = (pl_s1.kind == KIND_INV) ? pl_s1.a_re : pl_s1.b_re;
		ys = (pl_s1.kind == KIND_INV) ? pl_s1.a_im : pl_s1.b_im;
		mx = xs[31] ? 32'(-xs) : 32'(xs);
		my = ys[31] ? 32'(-ys) : 32'(ys);
		pl2_nxt      = pl_s1;
		pl2_nxt.mx   = mx;
		pl2_nxt.my   = my;
		pl2_nxt.negx = xs[31];
		pl2_nxt.negy = !ys[31] && (ys != 32'sd0);  // conj flips imag sign
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s2  <= pl2_nxt;
			sqx_s2 <= 64'(mx) * 64'(mx);
			sqy_s2 <= 64'(my) * 64'(my);
		end
	end

	// ---------------- stage 3
	logic [63:0] den;
	carry_t      pl3_nxt;
	assign den = sqx_s2 + sqy_s2;

	always_comb begin
		pl3_nxt     = pl_s2;
		pl3_nxt.den = den;
		pl3_nxt.dz  = (den == 64'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s3 <= pl3_nxt;
		end
	end

	// ---------------- stage 4: one quotient bit per stage, dividend |x| << 2F
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		localparam int I = DIV_STEPS - 1 - k;
		logic    pv;
		carry_t  pc;
		dstate_t px, py;
		logic    bx, by;

		if (k == 0) begin : g_first
			assign pv = vld_s3;
			assign pc = pl_s3;
			assign px = '0;
			assign py = '0;
		end else begin : g_next
			assign pv = vld_s4[k-1];
			assign pc = pl_s4[k-1];
			assign px = dx_s4[k-1];
			assign py = dy_s4[k-1];
		end

		if (I >= 2 * FRAC_BITS && I - 2 * FRAC_BITS < 32) begin : g_bit
			assign bx = pc.mx[I - 2 * FRAC_BITS];
			assign by = pc.my[I - 2 * FRAC_BITS];
		end else begin : g_zero
			assign bx = 1'b0;
			assign by = 1'b0;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s4[k] <= 1'b0;
			end else if (en) begin
				vld_s4[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pl_s4[k] <= pc;
				dx_s4[k] <= div_step(px, pc.den, bx);
				dy_s4[k] <= div_step(py, pc.den, by);
			end
		end
	end

	// ---------------- stage 5: round, sign, saturate the inverse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4[DIV_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s5  <= pl_s4[DIV_STEPS-1];
			ire_s5 <= inv_fin(dx_s4[DIV_STEPS-1], pl_s4[DIV_STEPS-1].den,
				pl_s4[DIV_STEPS-1].negx);
			iim_s5 <= inv_fin(dy_s4[DIV_STEPS-1], pl_s4[DIV_STEPS-1].den,
				pl_s4[DIV_STEPS-1].negy);
		end
	end

	// ---------------- stage 6: products, right operand is b or inverse(b)
	logic signed [31:0] ore, oim;
	carry_t             pl6_nxt;

	always_comb begin
		ore = (pl_s5.kind == KIND_DIV) ? ire_s5.val : pl_s5.b_re;
		oim = (pl_s5.kind == KIND_DIV) ? iim_s5.val : pl_s5.b_im;
		pl6_nxt = pl_s5;
		// inverse result rides in the b slots from here on
		if (pl_s5.kind == KIND_INV) begin
			pl6_nxt.b_re = ire_s5.val;
			pl6_nxt.b_im = iim_s5.val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s6   <= pl6_nxt;
			isat_s6 <= ire_s5.sat | iim_s5.sat;
			p0_s6   <= 64'(pl_s5.a_re) * 64'(ore);
			p1_s6   <= 64'(pl_s5.a_im) * 64'(oim);
			p2_s6   <= 64'(pl_s5.a_re) * 64'(oim);
			p3_s6   <= 64'(pl_s5.a_im) * 64'(ore);
		end
	end

	// ---------------- stage 7: sums, rounding, result select
	logic signed [64:0] sre, sim, rre, rim;
	logic signed [64:0] ar, ai, br, bi;
	satv_t              mre, mim, c_re, c_im;
	logic [63:0]        nxt_data;
	status_t            nxt_st;

	always_comb begin
		ar  = 65'(pl_s6.a_re);
		ai  = 65'(pl_s6.a_im);
		br  = 65'(pl_s6.b_re);
		bi  = 65'(pl_s6.b_im);
		sre = 65'(p0_s6) - 65'(p1_s6);
		sim = 65'(p2_s6) + 65'(p3_s6);
		rre = (sre >>> FRAC_BITS) + $signed({64'd0, sre[FRAC_BITS-1]});
		rim = (sim >>> FRAC_BITS) + $signed({64'd0, sim[FRAC_BITS-1]});
		mre = sat32(rre);
		mim = sat32(rim);
		c_re = '0;
		c_im = '0;
		unique case (pl_s6.kind)
			KIND_ADD: begin
				c_re = sat32(ar + br);
				c_im = sat32(ai + bi);
			end
			KIND_SUB: begin
				c_re = sat32(ar - br);
				c_im = sat32(ai - bi);
			end
			KIND_MUL: begin
				c_re = mre;
				c_im = mim;
			end
			KIND_DIV: begin
				c_re     = mre;
				c_im     = mim;
				c_re.sat = mre.sat | isat_s6;
			end
			KIND_NEG: begin
				c_re = sat32(-ar);
				c_im = sat32(-ai);
			end
			KIND_CONJ: begin
				c_re = sat32(ar);
				c_im = sat32(-ai);
			end
			KIND_INV: begin
				c_re.val = pl_s6.b_re;
				c_im.val = pl_s6.b_im;
				c_re.sat = isat_s6;
			end
			default: begin
				c_re = '0;
				c_im = '0;
			end
		endcase
		if (pl_s6.dz && (pl_s6.kind == KIND_DIV || pl_s6.kind == KIND_INV)) begin
			nxt_data = 64'd0;
			nxt_st   = ST_DZ;
		end else begin
			nxt_data = {c_im.val, c_re.val};
			nxt_st   = (c_re.sat | c_im.sat) ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s7 <= nxt_data;
			st_s7   <= nxt_st;
			kind_s7 <= pl_s6.kind;
		end
	end

	// ---------------- checks
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 && st_s7 == ST_DZ |-> data_s7 == 64'd0)
		else $error("divide-by-zero word with nonzero data");

	a_dz_kind: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 && st_s7 == ST_DZ |-> kind_s7 == KIND_DIV || kind_s7 == KIND_INV)
		else $error("divide-by-zero status on a non-dividing operation");

	a_unused_kind: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 && kind_s7 == KIND_RSVD |-> data_s7 == 64'd0 && st_s7 == ST_OK)
		else $error("unused kind produced data or status");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s6) && $stable(p0_s6) && $stable(pl_s6))
		else $error("pipe advanced while output stalled");

endmodule
